// ===== src/quaternion_multiply_rotate_defines.svh =====
// assertion macros for the quaternion multiply and rotate block
`ifndef QUATERNION_MULTIPLY_ROTATE_DEFINES_SVH
`define QUATERNION_MULTIPLY_ROTATE_DEFINES_SVH

// concurrent check on clk_i, suspended while rst_ni is low
`define QMR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// concurrent check on clk_i that also holds during reset
`define QMR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/qmr_pkg.sv =====
// shared types, constants and helpers of the quaternion multiply and rotate block
`default_nettype none

package qmr_pkg;

  localparam int unsigned QMR_COMP_W    = 16;
  localparam int unsigned QMR_PROD_W    = 2 * QMR_COMP_W;
  // four products plus the rounding half: two guard bits and one spare
  localparam int unsigned QMR_ACC_W     = QMR_PROD_W + 3;
  localparam int unsigned QMR_FRAC_BITS = 14;

  typedef logic signed [QMR_COMP_W-1:0] comp_t;
  typedef logic signed [QMR_PROD_W-1:0] prod_t;
  typedef logic signed [QMR_ACC_W-1:0]  acc_t;

  typedef enum logic [1:0] {
    MODE_PRODUCT = 2'd0,
    MODE_ROTATE  = 2'd1,
    MODE_CONJ    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
  } quat_t;

  // four raw products feeding one result component
  typedef struct packed {
    prod_t t0;
    prod_t t1;
    prod_t t2;
    prod_t t3;
  } terms_t;

  typedef struct packed {
    terms_t x;
    terms_t y;
    terms_t z;
    terms_t w;
  } qterms_t;

  localparam comp_t COMP_MAX = comp_t'(16'sh7FFF);
  localparam comp_t COMP_MIN = comp_t'(16'sh8000);

  function automatic prod_t mul16(input comp_t a, input comp_t b);
    prod_t r;
    r = prod_t'(a) * prod_t'(b);
    return r;
  endfunction

  // negate with saturation of the most negative code
  function automatic comp_t neg_sat(input comp_t a);
    comp_t r;
    r = (a == COMP_MIN) ? COMP_MAX : -a;
    return r;
  endfunction

  function automatic quat_t conj_sat(input quat_t a);
    quat_t r;
    r.x = neg_sat(a.x);
    r.y = neg_sat(a.y);
    r.z = neg_sat(a.z);
    r.w = a.w;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/qmr_mul.sv =====
// sixteen signed 16x16 products of one hamilton product
`default_nettype none

module qmr_mul (
  input  qmr_pkg::quat_t   p_i,
  input  qmr_pkg::quat_t   q_i,
  output qmr_pkg::qterms_t prods_o
);
  import qmr_pkg::*;

  always_comb begin
    prods_o.x.t0 = mul16(p_i.w, q_i.x);
    prods_o.x.t1 = mul16(p_i.x, q_i.w);
    prods_o.x.t2 = mul16(p_i.y, q_i.z);
    prods_o.x.t3 = mul16(p_i.z, q_i.y);

    prods_o.y.t0 = mul16(p_i.w, q_i.y);
    prods_o.y.t1 = mul16(p_i.x, q_i.z);
    prods_o.y.t2 = mul16(p_i.y, q_i.w);
    prods_o.y.t3 = mul16(p_i.z, q_i.x);

    prods_o.z.t0 = mul16(p_i.w, q_i.z);
    prods_o.z.t1 = mul16(p_i.x, q_i.y);
    prods_o.z.t2 = mul16(p_i.y, q_i.x);
    prods_o.z.t3 = mul16(p_i.z, q_i.w);

    prods_o.w.t0 = mul16(p_i.w, q_i.w);
    prods_o.w.t1 = mul16(p_i.x, q_i.x);
    prods_o.w.t2 = mul16(p_i.y, q_i.y);
    prods_o.w.t3 = mul16(p_i.z, q_i.z);
  end

endmodule

`default_nettype wire

// ===== src/qmr_sum.sv =====
// signed four-term sums with round half up and 16-bit saturation
`default_nettype none

module qmr_sum #(
  parameter int unsigned FRAC_BITS = qmr_pkg::QMR_FRAC_BITS
) (
  input  qmr_pkg::qterms_t prods_i,
  output qmr_pkg::quat_t   res_o
);
  import qmr_pkg::*;

  localparam acc_t HALF    = acc_t'(1) <<< (FRAC_BITS - 1);
  localparam acc_t SAT_MAX = acc_t'(COMP_MAX);
  localparam acc_t SAT_MIN = acc_t'(COMP_MIN);

  function automatic comp_t round_sat(input acc_t v);
    acc_t t;
    acc_t r;
    comp_t o;
    t = v + HALF;
    r = t >>> FRAC_BITS;
    if (r > SAT_MAX) begin
      o = COMP_MAX;
    end else if (r < SAT_MIN) begin
      o = COMP_MIN;
    end else begin
      o = comp_t'(r);
    end
    return o;
  endfunction

  acc_t sum_x, sum_y, sum_z, sum_w;

  // term signs of the hamilton product
  assign sum_x = acc_t'(prods_i.x.t0) + acc_t'(prods_i.x.t1)
               + acc_t'(prods_i.x.t2) - acc_t'(prods_i.x.t3);
  assign sum_y = acc_t'(prods_i.y.t0) - acc_t'(prods_i.y.t1)
               + acc_t'(prods_i.y.t2) + acc_t'(prods_i.y.t3);
  assign sum_z = acc_t'(prods_i.z.t0) + acc_t'(prods_i.z.t1)
               - acc_t'(prods_i.z.t2) + acc_t'(prods_i.z.t3);
  assign sum_w = acc_t'(prods_i.w.t0) - acc_t'(prods_i.w.t1)
               - acc_t'(prods_i.w.t2) - acc_t'(prods_i.w.t3);

  assign res_o.x = round_sat(sum_x);
  assign res_o.y = round_sat(sum_y);
  assign res_o.z = round_sat(sum_z);
  assign res_o.w = round_sat(sum_w);

endmodule

`default_nettype wire

// ===== src/quaternion_multiply_rotate.sv =====
// top level: four-stage quaternion product, vector rotation and conjugate pipeline
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+------------------------------------
//   in      | input     | in_valid_i / in_ready_o | mode_i, a_{x,y,z,w}_i, b_{x,y,z,w}_i
//   out     | output    | out_valid_o / out_ready_i | r_{x,y,z,w}_o
//
// one word enters per cycle while in_ready_o is high; its result passes stages 1 to 4 in order
// and waits, with out_valid_o high, in the stage 4 output register until out_ready_i takes it
// the stages are: products A*B; sum and round; products P*conj(A); sum, round and select
// each stage holds its word until the next one has room, so bubbles close up on a stall
// reset clears only the stage valid bits; data registers load without reset
// in_ready_o goes low only when every stage holds a word and the output is not taken
`default_nettype none

module quaternion_multiply_rotate #(
  parameter int unsigned FRAC_BITS = qmr_pkg::QMR_FRAC_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // input words
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    mode_i,
  input  qmr_pkg::comp_t a_x_i,
  input  qmr_pkg::comp_t a_y_i,
  input  qmr_pkg::comp_t a_z_i,
  input  qmr_pkg::comp_t a_w_i,
  input  qmr_pkg::comp_t b_x_i,
  input  qmr_pkg::comp_t b_y_i,
  input  qmr_pkg::comp_t b_z_i,
  input  qmr_pkg::comp_t b_w_i,
  // result words
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output qmr_pkg::comp_t r_x_o,
  output qmr_pkg::comp_t r_y_o,
  output qmr_pkg::comp_t r_z_o,
  output qmr_pkg::comp_t r_w_o
);
  import qmr_pkg::*;

  // per-stage advance: a stage loads when it is empty or its word moves on
  logic adv1, adv2, adv3, adv4;

  // stage valid bits
  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;

  // stage 1: first products, mode and conj(A) ride along
  mode_e   mode1_q, mode1_d;
  quat_t   conj1_q, conj1_d;
  qterms_t prod1_q, prod1_d;

  // stage 2: first product P rounded
  mode_e   mode2_q, mode2_d;
  quat_t   conj2_q, conj2_d;
  quat_t   p2_q, p2_d;

  // stage 3: second products P*conj(A)
  mode_e   mode3_q, mode3_d;
  quat_t   conj3_q, conj3_d;
  quat_t   p3_q, p3_d;
  qterms_t prod3_q, prod3_d;

  // stage 4: output register
  quat_t   res4_q, res4_d;

  quat_t   a_in, b_in, rot_res;
  mode_e   mode_in;

  assign adv4 = !v4_q || out_ready_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_ready_o = adv1;

  // input word unpacking; rotation treats B as a pure vector
  always_comb begin
    mode_in = mode_e'(mode_i);
    a_in.x  = a_x_i;
    a_in.y  = a_y_i;
    a_in.z  = a_z_i;
    a_in.w  = a_w_i;
    b_in.x  = b_x_i;
    b_in.y  = b_y_i;
    b_in.z  = b_z_i;
    b_in.w  = (mode_in == MODE_ROTATE) ? comp_t'(0) : b_w_i;
  end

  qmr_mul u_mul_ab (
    .p_i     (a_in),
    .q_i     (b_in),
    .prods_o (prod1_d)
  );

  assign mode1_d = mode_in;
  assign conj1_d = conj_sat(a_in);

  qmr_sum #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sum_ab (
    .prods_i (prod1_q),
    .res_o   (p2_d)
  );

  assign mode2_d = mode1_q;
  assign conj2_d = conj1_q;

  qmr_mul u_mul_pc (
    .p_i     (p2_q),
    .q_i     (conj2_q),
    .prods_o (prod3_d)
  );

  assign mode3_d = mode2_q;
  assign conj3_d = conj2_q;
  assign p3_d    = p2_q;

  qmr_sum #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sum_pc (
    .prods_i (prod3_q),
    .res_o   (rot_res)
  );

  // final selection by mode
  always_comb begin
    unique case (mode3_q)
      MODE_PRODUCT: res4_d = p3_q;
      MODE_ROTATE: begin
        res4_d   = rot_res;
        res4_d.w = comp_t'(0);
      end
      MODE_CONJ:    res4_d = conj3_q;
      default:      res4_d = '0;
    endcase
  end

  // valid bits follow the word that each stage loads
  assign v1_d = adv1 ? in_valid_i : v1_q;
  assign v2_d = adv2 ? v1_q : v2_q;
  assign v3_d = adv3 ? v2_q : v3_q;
  assign v4_d = adv4 ? v3_q : v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  // data registers, no reset
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      mode1_q <= mode1_d;
      conj1_q <= conj1_d;
      prod1_q <= prod1_d;
    end
    if (adv2) begin
      mode2_q <= mode2_d;
      conj2_q <= conj2_d;
      p2_q    <= p2_d;
    end
    if (adv3) begin
      mode3_q <= mode3_d;
      conj3_q <= conj3_d;
      p3_q    <= p3_d;
      prod3_q <= prod3_d;
    end
    if (adv4) begin
      res4_q  <= res4_d;
    end
  end

  assign out_valid_o = v4_q;
  assign r_x_o       = res4_q.x;
  assign r_y_o       = res4_q.y;
  assign r_z_o       = res4_q.z;
  assign r_w_o       = res4_q.w;

endmodule

`default_nettype wire

// ===== src/qmr_checker.sv =====
// port-level checks of the quaternion multiply and rotate block, bound to the top level
`default_nettype none
`include "quaternion_multiply_rotate_defines.svh"

module qmr_checker (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            in_ready_o,
  input wire            out_valid_o,
  input wire            out_ready_i,
  input qmr_pkg::comp_t r_x_o,
  input qmr_pkg::comp_t r_y_o,
  input qmr_pkg::comp_t r_z_o,
  input qmr_pkg::comp_t r_w_o
);

  wire [63:0] res_word  = {r_x_o, r_y_o, r_z_o, r_w_o};
  wire        out_stall = out_valid_o && !out_ready_i;

  // a stalled result stays put
  `QMR_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(res_word), "stalled result changed")

  // an empty output stage means the pipe has room
  `QMR_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input blocked with empty output")

  // a taken result frees a slot all the way to the input
  `QMR_ASSERT(a_ready_on_drain, out_ready_i |-> in_ready_o, "input blocked while output drains")

  // reset empties the pipe
  `QMR_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind quaternion_multiply_rotate qmr_checker u_qmr_checker (.*);

`default_nettype wire
